### rtl/pdm_pkg.sv
// pdm_pkg: shared types, constants and codes for the pixel difference mapper
// no dependencies; imported by every rtl file of the block
package pdm_pkg;

	// pixel code and difference widths
	localparam int PIX_W         = 10;
	localparam int DIFF_W        = PIX_W + 1;
	localparam int CODE_BITS_DEF = 10;
	localparam int LANES         = 3;

	// q16 fixed point of the mapping curve
	localparam int Q_FRAC = 16;
	localparam int Q_W    = Q_FRAC + 1;
	localparam logic [Q_W-1:0] Q_ONE = Q_W'(1 << Q_FRAC);
	localparam int PROD_W = Q_W + PIX_W;
	localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1 << (Q_FRAC - 1));

	// iteration counts of the divider and square root pipes
	localparam int DIV_STEPS  = Q_FRAC;
	localparam int SQRT_STEPS = Q_FRAC;

	// pipeline depths
	localparam int FRONT_LAT = 2;
	localparam int LANE_LAT  = 1 + DIV_STEPS + SQRT_STEPS + 3;
	localparam int PIPE_LAT  = FRONT_LAT + LANE_LAT;

	// rec.709 luma weights in q16, summing to one
	localparam int LUMA_PROD_W = 17 + PIX_W;
	localparam int LUMA_SUM_W  = LUMA_PROD_W + 1;
	localparam logic [16:0] LUMA_WT [LANES] = '{17'd13933, 17'd46871, 17'd4732};
	localparam logic [LUMA_SUM_W-1:0] LUMA_HALF = LUMA_SUM_W'(1 << (Q_FRAC - 1));

	// scale limits and reset value
	localparam logic [PIX_W-1:0] SCALE_MIN   = PIX_W'(4);
	localparam logic [PIX_W-1:0] SCALE_RESET = PIX_W'(1023);

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFF_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GREY_OUT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd2;

	// difference mapping modes
	typedef enum logic [1:0] {
		MODE_LEGACY = 2'd0,
		MODE_LINEAR = 2'd1,
		MODE_SQRT   = 2'd2,
		MODE_SIGNED = 2'd3
	} diff_mode_t;

	// configuration seen by the datapath
	typedef struct packed {
		diff_mode_t       mode;
		logic             grey_out;
		logic [PIX_W-1:0] full_scale;
	} cfg_t;

endpackage

### rtl/pixel_difference_mapper.sv
// pixel_difference_mapper: top level, config registers, three channel lanes and merge
// depends on pdm_pkg, pdm_front, pdm_lane
// path from input transaction to out_valid: front stages, lane stages, output register
// throughput: one pixel pair per clock; out_stall halts the whole pipe through in_stall
// reset: valid chain and output valid cleared, config back to legacy mode, rgb, scale 1023
module pixel_difference_mapper #(
	parameter int CODE_BITS = pdm_pkg::CODE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pdm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pdm_pkg::PIX_W-1:0]       cfg_data,
	// pixel pair input
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [pdm_pkg::PIX_W-1:0]       left_r,
	input  logic [pdm_pkg::PIX_W-1:0]       left_g,
	input  logic [pdm_pkg::PIX_W-1:0]       left_b,
	input  logic [pdm_pkg::PIX_W-1:0]       right_r,
	input  logic [pdm_pkg::PIX_W-1:0]       right_g,
	input  logic [pdm_pkg::PIX_W-1:0]       right_b,
	input  logic                            last_in_row,
	// difference pixel output
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [pdm_pkg::PIX_W-1:0]       out_r,
	output logic [pdm_pkg::PIX_W-1:0]       out_g,
	output logic [pdm_pkg::PIX_W-1:0]       out_b,
	output logic                            row_end
);
	import pdm_pkg::*;

	cfg_t cfg_q;
	logic en;

	logic [PIX_W-1:0]         left_c  [LANES];
	logic [PIX_W-1:0]         right_c [LANES];
	logic signed [DIFF_W-1:0] diff_c  [LANES];
	logic [PIX_W-1:0]         code_c  [LANES];

	logic [PIPE_LAT-1:0] vld_s;
	logic [PIPE_LAT-1:0] last_s;

	logic             out_valid_q;
	logic [PIX_W-1:0] out_r_q;
	logic [PIX_W-1:0] out_g_q;
	logic [PIX_W-1:0] out_b_q;
	logic             row_end_q;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= MODE_LEGACY;
			cfg_q.grey_out   <= 1'b0;
			cfg_q.full_scale <= SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DIFF_MODE:  cfg_q.mode       <= diff_mode_t'(cfg_data[1:0]);
				CFG_GREY_OUT:   cfg_q.grey_out   <= cfg_data[0];
				CFG_FULL_SCALE: cfg_q.full_scale <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipe advances unless a finished transaction is held at the output
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	assign left_c[0]  = left_r;
	assign left_c[1]  = left_g;
	assign left_c[2]  = left_b;
	assign right_c[0] = right_r;
	assign right_c[1] = right_g;
	assign right_c[2] = right_b;

	pdm_front u_front (
		.clk   (clk),
		.en    (en),
		.cfg   (cfg_q),
		.left  (left_c),
		.right (right_c),
		.diff  (diff_c)
	);

	for (genvar c = 0; c < LANES; c++) begin : g_lane
		pdm_lane #(
			.CODE_BITS (CODE_BITS)
		) u_lane (
			.clk  (clk),
			.en   (en),
			.cfg  (cfg_q),
			.diff (diff_c[c]),
			.code (code_c[c])
		);
	end

	// valid chain alongside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_LAT-2:0], in_valid};
		end
	end

	// row marker rides with the pixel
	always_ff @(posedge clk) begin
		if (en) begin
			last_s <= {last_s[PIPE_LAT-2:0], last_in_row};
		end
	end

	// merge: grey output copies the luma lane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s[PIPE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_s[PIPE_LAT-1]) begin
			out_r_q   <= code_c[0];
			out_g_q   <= cfg_q.grey_out ? code_c[0] : code_c[1];
			out_b_q   <= cfg_q.grey_out ? code_c[0] : code_c[2];
			row_end_q <= last_s[PIPE_LAT-1];
		end
	end

	assign out_valid = out_valid_q;
	assign out_r     = out_r_q;
	assign out_g     = out_g_q;
	assign out_b     = out_b_q;
	assign row_end   = row_end_q;

endmodule

### rtl/pdm_front.sv
// pdm_front: luma products and per-lane signed differences, two stages
// depends on pdm_pkg
module pdm_front (
	input  logic                             clk,
	input  logic                             en,
	input  pdm_pkg::cfg_t                    cfg,
	input  logic [pdm_pkg::PIX_W-1:0]        left  [pdm_pkg::LANES],
	input  logic [pdm_pkg::PIX_W-1:0]        right [pdm_pkg::LANES],
	output logic signed [pdm_pkg::DIFF_W-1:0] diff [pdm_pkg::LANES]
);
	import pdm_pkg::*;

	logic [LUMA_PROD_W-1:0] lprod_s1 [LANES];
	logic [LUMA_PROD_W-1:0] rprod_s1 [LANES];
	logic [PIX_W-1:0]       left_s1  [LANES];
	logic [PIX_W-1:0]       right_s1 [LANES];
	logic [LUMA_SUM_W-1:0]  lsum;
	logic [LUMA_SUM_W-1:0]  rsum;
	logic [PIX_W-1:0]       yl;
	logic [PIX_W-1:0]       yr;
	logic signed [DIFF_W-1:0] diff_s2 [LANES];

	// stage 1: weighted channels for both pixels
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < LANES; c++) begin
				lprod_s1[c] <= LUMA_PROD_W'(LUMA_WT[c]) * LUMA_PROD_W'(left[c]);
				rprod_s1[c] <= LUMA_PROD_W'(LUMA_WT[c]) * LUMA_PROD_W'(right[c]);
				left_s1[c]  <= left[c];
				right_s1[c] <= right[c];
			end
		end
	end

	// luma with rounding
	always_comb begin
		lsum = LUMA_HALF;
		rsum = LUMA_HALF;
		for (int c = 0; c < LANES; c++) begin
			lsum = lsum + LUMA_SUM_W'(lprod_s1[c]);
			rsum = rsum + LUMA_SUM_W'(rprod_s1[c]);
		end
		yl = lsum[Q_FRAC +: PIX_W];
		yr = rsum[Q_FRAC +: PIX_W];
	end

	// stage 2: lane 0 takes the luma difference in grey mode
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < LANES; c++) begin
				if (c == 0 && cfg.grey_out) begin
					diff_s2[c] <= $signed({1'b0, yl}) - $signed({1'b0, yr});
				end else begin
					diff_s2[c] <= $signed({1'b0, left_s1[c]})
						- $signed({1'b0, right_s1[c]});
				end
			end
		end
	end

	assign diff = diff_s2;

endmodule

### rtl/pdm_lane.sv
// pdm_lane: maps one signed difference to an output code, 36 stages
// depends on pdm_pkg; a restoring divider and a digit square root pipe
module pdm_lane #(
	parameter int CODE_BITS = pdm_pkg::CODE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  pdm_pkg::cfg_t                     cfg,
	input  logic signed [pdm_pkg::DIFF_W-1:0] diff,
	output logic [pdm_pkg::PIX_W-1:0]         code
);
	import pdm_pkg::*;

	localparam logic [PIX_W-1:0] MAXC = PIX_W'((1 << CODE_BITS) - 1);
	localparam logic [PIX_W-1:0] MIDC = MAXC >> 1;
	localparam int REM_W = SQRT_STEPS + 1;
	localparam int CUR_W = REM_W + 2;

	typedef struct packed {
		logic             sat;
		logic             neg;
		logic [PIX_W-1:0] leg;
	} meta_t;

	logic [PIX_W-1:0] mag;
	logic [PIX_W:0]   dbl;
	logic [PIX_W-1:0] leg_c;
	logic [PIX_W-1:0] a_c;
	logic [PIX_W-1:0] s_c;

	logic [PIX_W-1:0]     drem_s  [0:DIV_STEPS];
	logic [PIX_W-1:0]     dden_s  [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] dq_s    [0:DIV_STEPS];
	meta_t                dmeta_s [0:DIV_STEPS];
	logic [Q_W-1:0]       x_c;

	logic [SQRT_STEPS-1:0] sroot_s [1:SQRT_STEPS];
	logic [REM_W-1:0]      srem_s  [1:SQRT_STEPS];
	logic [DIV_STEPS-1:0]  srad_s  [1:SQRT_STEPS];
	logic [Q_W-1:0]        sx_s    [1:SQRT_STEPS];
	meta_t                 smeta_s [1:SQRT_STEPS];

	logic [Q_W-1:0]    y_c;
	logic [Q_W-1:0]    y_s34;
	meta_t             meta_s34;
	logic [PIX_W-1:0]  coef;
	logic [PROD_W-1:0] prod_s35;
	meta_t             meta_s35;
	logic [PROD_W:0]   rsum;
	logic [PIX_W-1:0]  v;
	logic [PIX_W-1:0]  code_c;
	logic [PIX_W-1:0]  code_s36;

	// magnitude, legacy result, clamped magnitude and scale
	always_comb begin
		mag   = diff[DIFF_W-1] ? PIX_W'(-diff) : PIX_W'(diff);
		dbl   = {mag, 1'b0};
		leg_c = (dbl > {1'b0, MAXC}) ? MAXC : dbl[PIX_W-1:0];
		a_c   = (mag > MAXC) ? MAXC : mag;
		if (cfg.full_scale < SCALE_MIN) begin
			s_c = SCALE_MIN;
		end else if (cfg.full_scale > MAXC) begin
			s_c = MAXC;
		end else begin
			s_c = cfg.full_scale;
		end
	end

	// stage 1: load the divider
	always_ff @(posedge clk) begin
		if (en) begin
			drem_s[0]  <= a_c;
			dden_s[0]  <= s_c;
			dq_s[0]    <= '0;
			dmeta_s[0] <= '{sat: (a_c >= s_c), neg: diff[DIFF_W-1], leg: leg_c};
		end
	end

	// stages 2..17: one quotient bit each
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		logic [PIX_W:0] cur;
		logic           ge;
		assign cur = {drem_s[k-1], 1'b0};
		assign ge  = cur >= {1'b0, dden_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				drem_s[k]  <= ge ? PIX_W'(cur - {1'b0, dden_s[k-1]}) : cur[PIX_W-1:0];
				dden_s[k]  <= dden_s[k-1];
				dq_s[k]    <= {dq_s[k-1][DIV_STEPS-2:0], ge};
				dmeta_s[k] <= dmeta_s[k-1];
			end
		end
	end

	// q16 ratio, saturated at one
	assign x_c = dmeta_s[DIV_STEPS].sat ? Q_ONE : {1'b0, dq_s[DIV_STEPS]};

	// stages 18..33: one root bit each, low half of the radicand is zero
	for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
		logic [SQRT_STEPS-1:0] root_p;
		logic [REM_W-1:0]      rem_p;
		logic [DIV_STEPS-1:0]  rad_p;
		logic [Q_W-1:0]        x_p;
		meta_t                 meta_p;
		logic [CUR_W-1:0]      cur;
		logic [CUR_W-1:0]      trial;
		logic                  ge;
		if (j == 1) begin : g_first
			assign root_p = '0;
			assign rem_p  = '0;
			assign rad_p  = x_c[DIV_STEPS-1:0];
			assign x_p    = x_c;
			assign meta_p = dmeta_s[DIV_STEPS];
		end else begin : g_next
			assign root_p = sroot_s[j-1];
			assign rem_p  = srem_s[j-1];
			assign rad_p  = srad_s[j-1];
			assign x_p    = sx_s[j-1];
			assign meta_p = smeta_s[j-1];
		end
		assign cur   = {rem_p, rad_p[DIV_STEPS-1 -: 2]};
		assign trial = {1'b0, root_p, 2'b01};
		assign ge    = cur >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				sroot_s[j] <= {root_p[SQRT_STEPS-2:0], ge};
				srem_s[j]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
				srad_s[j]  <= {rad_p[DIV_STEPS-3:0], 2'b00};
				sx_s[j]    <= x_p;
				smeta_s[j] <= meta_p;
			end
		end
	end

	// round the root to nearest, one when saturated, or pass the ratio in linear mode
	always_comb begin
		if (cfg.mode == MODE_LINEAR) begin
			y_c = sx_s[SQRT_STEPS];
		end else if (smeta_s[SQRT_STEPS].sat) begin
			y_c = Q_ONE;
		end else if (srem_s[SQRT_STEPS] > {1'b0, sroot_s[SQRT_STEPS]}) begin
			y_c = {1'b0, sroot_s[SQRT_STEPS]} + Q_W'(1);
		end else begin
			y_c = {1'b0, sroot_s[SQRT_STEPS]};
		end
	end

	// stage 34: curve value
	always_ff @(posedge clk) begin
		if (en) begin
			y_s34    <= y_c;
			meta_s34 <= smeta_s[SQRT_STEPS];
		end
	end

	// stage 35: scale to full or half range
	assign coef = (cfg.mode == MODE_SIGNED) ? MIDC : MAXC;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s35 <= PROD_W'(y_s34) * PROD_W'(coef);
			meta_s35 <= meta_s34;
		end
	end

	// stage 36: round and pick the mode result
	always_comb begin
		rsum = (PROD_W + 1)'(prod_s35) + ROUND_HALF;
		v    = rsum[Q_FRAC +: PIX_W];
		case (cfg.mode)
			MODE_LEGACY: code_c = meta_s35.leg;
			MODE_SIGNED: code_c = meta_s35.neg ? (MIDC - v) : (MIDC + v);
			default:     code_c = v;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_s36 <= code_c;
		end
	end

	assign code = code_s36;

endmodule

### rtl/pdm_checker.sv
// pdm_checker: port level assertions for pixel_difference_mapper, bound to the top
// depends on pdm_pkg and the top level port list
module pdm_checker #(
	parameter int CODE_BITS = pdm_pkg::CODE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [pdm_pkg::PIX_W-1:0]     out_r,
	input logic [pdm_pkg::PIX_W-1:0]     out_g,
	input logic [pdm_pkg::PIX_W-1:0]     out_b,
	input logic                          row_end
);
	import pdm_pkg::*;

	localparam logic [PIX_W-1:0] MAXC = PIX_W'((1 << CODE_BITS) - 1);

	// input back-pressure only comes from a held output transaction
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("in_stall does not follow the held output");

	// every code stays within the range set by CODE_BITS
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_r <= MAXC && out_g <= MAXC && out_b <= MAXC))
		else $error("output code above max");

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a stalled result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
		$stable(out_r) && $stable(out_g) && $stable(out_b) && $stable(row_end))
		else $error("output changed while stalled");

endmodule

bind pixel_difference_mapper pdm_checker #(.CODE_BITS(CODE_BITS)) u_pdm_checker (.*);
